// ----- sv/ahd_pkg.sv -----
// Shared types and constants for the at-sign hex escape decoder.
package ahd_pkg;

	// Characters the decoder looks for
	localparam logic [7:0] AT_CHAR   = 8'h40;
	localparam logic [7:0] ZERO_CHAR = 8'h30;
	localparam logic [7:0] TWO_CHAR  = 8'h32;
	localparam logic [7:0] SEVEN_CHAR = 8'h37;

	// Pending token progress: how many token bytes are held
	localparam logic [2:0] CNT_NONE  = 3'd0;
	localparam logic [2:0] CNT_AT    = 3'd1;
	localparam logic [2:0] CNT_AT0   = 3'd2;
	localparam logic [2:0] CNT_AT00  = 3'd3;
	localparam logic [2:0] CNT_DIGIT = 3'd4;

	// Command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// One command: emit the first pre_cnt bytes of "@00<digit>", then the tail byte
	typedef struct packed {
		logic [2:0] pre_cnt;
		logic [7:0] digit;
		logic       tail_vld;
		logic [7:0] tail;
		logic       last;
	} ahd_cmd_t;

	// Lower-case hex digit test
	function automatic logic is_hex_lower(input logic [7:0] c);
		return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66));
	endfunction

	// Nibble value of a lower-case hex digit
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		if ((c >= 8'h61) && (c <= 8'h66))
			return c[3:0] + 4'd9;
		return c[3:0];
	endfunction

	// Is (hi, lo) one of the accepted punctuation codes
	function automatic logic code_listed(input logic [7:0] hi, input logic [7:0] lo);
		logic ok;
		ok = 1'b0;
		unique case (hi)
			8'h32: ok = is_hex_lower(lo);
			8'h33: ok = (lo >= 8'h61) && (lo <= 8'h66);
			8'h34: ok = (lo == 8'h30);
			8'h35: ok = (lo >= 8'h62) && (lo <= 8'h65);
			8'h36: ok = (lo == 8'h30);
			8'h37: ok = (lo >= 8'h62) && (lo <= 8'h65);
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

// ----- sv/ahd_front.sv -----
// Front end: accepts input bytes, tracks the pending token, issues output commands.
module ahd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	output logic             in_rdy,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output logic             push,
	output ahd_pkg::ahd_cmd_t cmd,
	input  logic             q_full
);
	import ahd_pkg::*;

	logic [2:0] held_count_q;
	logic [7:0] held_digit_q;
	logic [2:0] cnt_n;
	logic [7:0] dig_n;
	logic       mismatch;
	logic       acc;

	assign in_rdy = !q_full;
	assign acc    = in_vld && in_rdy;

	// Classify the byte against the pending token
	always_comb begin
		cnt_n        = held_count_q;
		dig_n        = held_digit_q;
		mismatch     = 1'b0;
		cmd.pre_cnt  = CNT_NONE;
		cmd.digit    = held_digit_q;
		cmd.tail_vld = 1'b0;
		cmd.tail     = in_byte;
		cmd.last     = in_last;
		unique case (held_count_q)
			CNT_AT, CNT_AT0: begin
				if (in_byte == ZERO_CHAR)
					cnt_n = held_count_q + 3'd1;
				else
					mismatch = 1'b1;
			end
			CNT_AT00: begin
				if ((in_byte >= TWO_CHAR) && (in_byte <= SEVEN_CHAR)) begin
					dig_n = in_byte;
					cnt_n = CNT_DIGIT;
				end else begin
					mismatch = 1'b1;
				end
			end
			CNT_DIGIT: begin
				if (code_listed(held_digit_q, in_byte)) begin
					cnt_n        = CNT_NONE;
					dig_n        = 8'h00;
					cmd.tail_vld = 1'b1;
					cmd.tail     = {held_digit_q[3:0], hex_value(in_byte)};
				end else begin
					mismatch = 1'b1;
				end
			end
			default: begin
				cnt_n = CNT_NONE;
				dig_n = 8'h00;
				if (in_byte == AT_CHAR)
					cnt_n = CNT_AT;
				else
					cmd.tail_vld = 1'b1;
			end
		endcase

		// Failed token: flush held bytes, then handle the byte afresh
		if (mismatch) begin
			cmd.pre_cnt = held_count_q;
			cnt_n       = CNT_NONE;
			dig_n       = 8'h00;
			if (in_byte == AT_CHAR)
				cnt_n = CNT_AT;
			else
				cmd.tail_vld = 1'b1;
		end

		// End of name: flush whatever is still held
		if (in_last) begin
			if (!cmd.tail_vld) begin
				if (cmd.pre_cnt != CNT_NONE) begin
					cmd.tail_vld = 1'b1;
					cmd.tail     = AT_CHAR;
				end else begin
					cmd.pre_cnt = cnt_n;
					cmd.digit   = dig_n;
				end
			end
			cnt_n = CNT_NONE;
			dig_n = 8'h00;
		end
	end

	assign push = acc && ((cmd.pre_cnt != CNT_NONE) || cmd.tail_vld);

	// Token state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= CNT_NONE;
			held_digit_q <= 8'h00;
		end else if (acc) begin
			held_count_q <= cnt_n;
			held_digit_q <= dig_n;
		end
	end

endmodule

// ----- sv/ahd_queue.sv -----
// Short command queue between front and back.
module ahd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ahd_pkg::ahd_cmd_t wr_cmd,
	output logic              full,
	input  logic              pop,
	output ahd_pkg::ahd_cmd_t rd_cmd,
	output logic              not_empty
);
	import ahd_pkg::*;

	ahd_cmd_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_cmd    = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_cmd;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- sv/ahd_back.sv -----
// Back end: expands commands into output bytes, one per cycle while the output is not stalled, into an output register.
module ahd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ahd_pkg::ahd_cmd_t q_cmd,
	input  logic              q_not_empty,
	output logic              pop,
	output logic              out_vld,
	input  logic              out_rdy,
	output logic [7:0]        out_byte,
	output logic              out_run_last,
	output logic              out_name_end
);
	import ahd_pkg::*;

	ahd_cmd_t   cur_q;
	logic       cur_vld_q;
	logic [2:0] pos_q;
	logic       out_vld_q;
	logic [7:0] out_byte_q;
	logic       out_run_last_q;
	logic       out_name_end_q;
	logic [2:0] total;
	logic       adv;
	logic       final_byte;
	logic [7:0] sel_byte;

	assign total      = cur_q.pre_cnt + {2'b00, cur_q.tail_vld};
	assign adv        = cur_vld_q && (!out_vld_q || out_rdy);
	assign final_byte = (pos_q == total - 3'd1);
	assign pop        = q_not_empty && (!cur_vld_q || (adv && final_byte));

	// Pick the byte at the current position of the command
	always_comb begin
		sel_byte = cur_q.tail;
		if (pos_q < cur_q.pre_cnt) begin
			unique case (pos_q)
				3'd0:    sel_byte = AT_CHAR;
				3'd1:    sel_byte = ZERO_CHAR;
				3'd2:    sel_byte = ZERO_CHAR;
				default: sel_byte = cur_q.digit;
			endcase
		end
	end

	// Current command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			pos_q     <= 3'd0;
		end else begin
			if (pop) begin
				cur_vld_q <= 1'b1;
				pos_q     <= 3'd0;
			end else if (adv) begin
				if (final_byte)
					cur_vld_q <= 1'b0;
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_cmd;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (out_rdy) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q     <= sel_byte;
			out_run_last_q <= final_byte;
			out_name_end_q <= final_byte && cur_q.last;
		end
	end

	assign out_vld      = out_vld_q;
	assign out_byte     = out_byte_q;
	assign out_run_last = out_run_last_q;
	assign out_name_end = out_name_end_q;

endmodule

// ----- sv/at_hex_escape_decoder_core.sv -----
// A byte that produces output passes the command queue, the current-command register and the output register first.
// Throughput: one input byte per cycle; one output byte per cycle while m_tready is high, a byte causing at most five.
// A four-entry command queue absorbs output bursts; input stalls only when the queue is full.
// Reset (arst_n low, asynchronous) clears the pending token, the queue and the output register.
module at_hex_escape_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // run_last
	output logic       m_tlast    // name_end
);
	import ahd_pkg::*;

	ahd_cmd_t wr_cmd;
	ahd_cmd_t rd_cmd;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_not_empty;

	ahd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (s_tvalid),
		.in_rdy  (s_tready),
		.in_byte (s_tdata),
		.in_last (s_tlast),
		.push    (push),
		.cmd     (wr_cmd),
		.q_full  (q_full)
	);

	ahd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (wr_cmd),
		.full      (q_full),
		.pop       (pop),
		.rd_cmd    (rd_cmd),
		.not_empty (q_not_empty)
	);

	ahd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_cmd        (rd_cmd),
		.q_not_empty  (q_not_empty),
		.pop          (pop),
		.out_vld      (m_tvalid),
		.out_rdy      (m_tready),
		.out_byte     (m_tdata),
		.out_run_last (m_tuser),
		.out_name_end (m_tlast)
	);

endmodule

// ----- sim/at_hex_escape_decoder_checker.sv -----
// Stream checker for the at-sign hex escape decoder: predicts the decoded bytes and compares them.
module at_hex_escape_decoder_checker
	import ahd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int unsigned fail_cnt,
	output int unsigned pending
);

	localparam logic [7:0] NINE_CHAR = 8'h39;
	localparam logic [7:0] LC_A      = 8'h61;
	localparam logic [7:0] LC_F      = 8'h66;

	// One decoded byte with its flags
	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       name_end;
	} dec_byte_t;

	dec_byte_t   due_bytes[$];
	logic [7:0]  step_out[$];
	logic [2:0]  tok_cnt;
	logic [7:0]  tok_digit;
	dec_byte_t   want;
	int unsigned errs;

	// Send '@' and whatever token bytes are held, then drop the token
	task automatic spill_token();
		if (tok_cnt >= CNT_AT && tok_cnt <= CNT_DIGIT) begin
			step_out.insert(step_out.size(), AT_CHAR);
			if (tok_cnt >= CNT_AT0)
				step_out.insert(step_out.size(), ZERO_CHAR);
			if (tok_cnt >= CNT_AT00)
				step_out.insert(step_out.size(), ZERO_CHAR);
			if (tok_cnt == CNT_DIGIT)
				step_out.insert(step_out.size(), tok_digit);
		end
		tok_cnt   = CNT_NONE;
		tok_digit = 8'h00;
	endtask

	// Advance the token tracker by one request and queue the bytes it yields
	task automatic decode_byte(input logic [7:0] b, input logic last);
		logic       pass_on;
		logic       lo_hex;
		logic       is_code;
		logic [7:0] code;
		int         n;
		pass_on = 1'b0;
		step_out.delete();
		lo_hex  = (b >= ZERO_CHAR && b <= NINE_CHAR) || (b >= LC_A && b <= LC_F);
		code    = {tok_digit[3:0], b[3:0] + ((b >= LC_A) ? 4'd9 : 4'd0)};
		is_code = lo_hex && ((code >= 8'h20 && code <= 8'h2f) ||
			(code >= 8'h3a && code <= 8'h3f) || code == 8'h40 ||
			(code >= 8'h5b && code <= 8'h5e) || code == 8'h60 ||
			(code >= 8'h7b && code <= 8'h7e));
		case (tok_cnt)
			CNT_AT, CNT_AT0: begin
				if (b == ZERO_CHAR)
					tok_cnt = tok_cnt + 3'd1;
				else
					pass_on = 1'b1;
			end
			CNT_AT00: begin
				if (b >= TWO_CHAR && b <= SEVEN_CHAR) begin
					tok_digit = b;
					tok_cnt   = CNT_DIGIT;
				end else begin
					pass_on = 1'b1;
				end
			end
			CNT_DIGIT: begin
				if (is_code) begin
					step_out.insert(step_out.size(), code);
					tok_cnt   = CNT_NONE;
					tok_digit = 8'h00;
				end else begin
					pass_on = 1'b1;
				end
			end
			default: begin
				tok_cnt   = CNT_NONE;
				tok_digit = 8'h00;
				pass_on   = 1'b1;
			end
		endcase
		// broken token goes out as it came; the new byte is then taken fresh
		if (pass_on) begin
			spill_token();
			if (b == AT_CHAR)
				tok_cnt = CNT_AT;
			else
				step_out.insert(step_out.size(), b);
		end
		// partial token at end of name is flushed as it stands
		if (last)
			spill_token();
		n = step_out.size();
		for (int i = 0; i < n; i++)
			due_bytes.insert(due_bytes.size(),
				dec_byte_t'({step_out[i], i == n - 1, last && (i == n - 1)}));
	endtask

	// Compare each accepted output with the oldest prediction, then predict new requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_bytes.delete();
			tok_cnt   = CNT_NONE;
			tok_digit = 8'h00;
			errs      = 0;
			fail_cnt <= 0;
			pending  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_bytes.size() == 0) begin
					$error("out_byte: expected nothing, got %h", m_tdata);
					errs++;
				end else begin
					want = due_bytes.pop_front();
					if (m_tdata !== want.data) begin
						$error("out_byte: expected %h, got %h", want.data, m_tdata);
						errs++;
					end
					if (m_tuser !== want.run_last) begin
						$error("run_last: expected %b, got %b", want.run_last, m_tuser);
						errs++;
					end
					if (m_tlast !== want.name_end) begin
						$error("name_end: expected %b, got %b", want.name_end, m_tlast);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			fail_cnt <= errs;
			pending  <= due_bytes.size();
		end
	end

endmodule

// ----- sim/at_hex_escape_decoder_core_tb.sv -----
// Testbench top for the at-sign hex escape decoder: clock, reset, name stimulus and verdict.
module at_hex_escape_decoder_core_tb;
	import ahd_pkg::*;

	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned RANDOM_BYTES = 420;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam logic [7:0]  LC_A         = 8'h61;
	localparam logic [7:0]  UC_A         = 8'h41;

	// Receiver stall styles
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MASK} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	int unsigned fail_cnt;
	int unsigned pending;

	logic [7:0]  name_buf[$];
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned rand_sent = 0;
	rx_mode_t    rx_mode;
	int unsigned rx_left = 0;
	logic [7:0]  rx_mask;
	logic [2:0]  rx_phase = 3'd0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	at_hex_escape_decoder_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	at_hex_escape_decoder_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.fail_cnt (fail_cnt),
		.pending  (pending)
	);

	// Receiver: picks a stall style for a random stretch of cycles
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_mask <= 8'($urandom_range(1, 255));
			rx_left <= $urandom_range(20, 120);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_phase <= rx_phase + 3'd1;
		case (rx_mode)
			RX_COIN: m_tready <= ($urandom_range(0, 2) != 0);
			RX_MASK: m_tready <= rx_mask[rx_phase];
			default: m_tready <= 1'b1;
		endcase
	end

	// Watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	function automatic logic [7:0] hex_ch(input logic [3:0] n);
		return (n < 4'd10) ? ZERO_CHAR + n : LC_A + n - 8'd10;
	endfunction

	// Append one byte to the name being built
	task automatic add_byte(input logic [7:0] b);
		name_buf.insert(name_buf.size(), b);
	endtask

	// Offer one request; bursts of random length with random gaps between them
	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) :
				$urandom_range(1, 24);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_name();
		int unsigned n;
		n = name_buf.size();
		for (int i = 0; i < n; i++)
			send_byte(name_buf[i], i == n - 1);
		name_buf.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// Sender holds off until every predicted byte has come out
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Append an escape token for a listed code, intact or damaged
	task automatic add_token(input bit intact);
		logic [7:0]  code;
		logic [7:0]  tok [0:4];
		int unsigned idx;
		int unsigned keep;
		int unsigned pos;
		idx = $urandom_range(0, 31);
		if (idx < 16)
			code = 8'h20 + 8'(idx);
		else if (idx < 22)
			code = 8'h3a + 8'(idx) - 8'd16;
		else if (idx == 22)
			code = 8'h40;
		else if (idx < 27)
			code = 8'h5b + 8'(idx) - 8'd23;
		else if (idx == 27)
			code = 8'h60;
		else
			code = 8'h7b + 8'(idx) - 8'd28;
		tok[0] = AT_CHAR;
		tok[1] = ZERO_CHAR;
		tok[2] = ZERO_CHAR;
		tok[3] = hex_ch(code[7:4]);
		tok[4] = hex_ch(code[3:0]);
		keep   = 5;
		if (!intact) begin
			case ($urandom_range(0, 3))
				0: keep = $urandom_range(1, 4);
				// upper-case low digit is not a token
				1: begin
					if (tok[4] >= LC_A)
						tok[4] = tok[4] - 8'h20;
					else
						tok[4] = UC_A + 8'($urandom_range(0, 5));
				end
				2: begin
					pos      = $urandom_range(1, 4);
					tok[pos] = 8'($urandom_range(0, 255));
				end
				// any digit pair, mostly unlisted
				default: begin
					tok[3] = ZERO_CHAR + 8'($urandom_range(0, 9));
					tok[4] = hex_ch(4'($urandom_range(0, 15)));
				end
			endcase
		end
		for (int i = 0; i < keep; i++)
			add_byte(tok[i]);
	endtask

	// Random name: mostly tokens, some broken ones and loose bytes
	task automatic add_random_name();
		int unsigned parts;
		parts = $urandom_range(1, 6);
		repeat (parts) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: add_token(1'b1);
				5, 6:          add_token(1'b0);
				7:             add_byte(8'($urandom_range(0, 255)));
				8:             add_byte($urandom_range(0, 1) ? AT_CHAR : ZERO_CHAR);
				default:       add_byte(8'($urandom_range(8'h20, 8'h7e)));
			endcase
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tlast  <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// byte extremes, a good token, an upper-case near miss at end of name
		add_byte(8'h00);
		add_byte(8'hff);
		add_text("@0020@002F");
		send_name();
		// second '@' restarts the token; partial token flushed at end of name
		add_text("@@0");
		send_name();
		// high digit out of range, then a token ending the name
		add_text("@008@007e");
		send_name();
		// lone '@' as a whole name
		add_text("@");
		send_name();
		hold_until_drained();

		while (rand_sent < RANDOM_BYTES) begin
			add_random_name();
			rand_sent += name_buf.size();
			if ($urandom_range(0, 24) == 0)
				hold_until_drained();
			send_name();
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/ahd_pkg.sv
sv/ahd_front.sv
sv/ahd_queue.sv
sv/ahd_back.sv
sv/at_hex_escape_decoder_core.sv
sim/at_hex_escape_decoder_checker.sv
sim/at_hex_escape_decoder_core_tb.sv
